@@ rtl/core/sorted_property_record_lookup_defines.svh @@
// Assertion macros shared by the property record lookup RTL.
`ifndef SORTED_PROPERTY_RECORD_LOOKUP_DEFINES_SVH
`define SORTED_PROPERTY_RECORD_LOOKUP_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked assertion, off while reset is asserted.
`define SPLK_ASSERT(lbl, clk, rstn, prop, msg) lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked assertion that also checks during reset.
`define SPLK_ASSERT_RST(lbl, clk, prop, msg) lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPLK_ASSERT(lbl, clk, rstn, prop, msg)
`define SPLK_ASSERT_RST(lbl, clk, prop, msg)
`endif

`endif

@@ rtl/core/splk_pkg.sv @@
// Shared constants and types of the property record lookup.
package splk_pkg;

    localparam int BYTE_W      = 8;
    localparam int CODE_W      = 31;
    localparam int WORD_W      = 32;
    localparam int SIZE_W      = 4;
    localparam int POS_W       = 13;
    localparam int DEF_MAX_STRING_BYTES = 4096;

    localparam logic [5:0] CODE_LOW_MASK = 6'h3F;

    typedef struct packed {
        logic              found;
        logic [WORD_W-1:0] value_low;
        logic [WORD_W-1:0] value_high;
        logic [SIZE_W-1:0] data_size;
        logic [POS_W-1:0]  position;
        logic              truncated;
    } t_result;

endpackage

@@ rtl/core/splk_parser.sv @@
// Byte-wise record parser: key decode, compare, data gather and result build.
`include "sorted_property_record_lookup_defines.svh"

module splk_parser #(
    parameter int MAX_STRING_BYTES = splk_pkg::DEF_MAX_STRING_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [splk_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                          i_last_byte,
    input  logic [splk_pkg::CODE_W-1:0]   i_wanted_code,
    output logic                          o_emit,
    output splk_pkg::t_result             o_result
);

    localparam int CNT_W    = $clog2(MAX_STRING_BYTES + 1);
    localparam int OFFSET_W = (CNT_W > splk_pkg::POS_W) ? CNT_W : splk_pkg::POS_W;
    localparam logic [OFFSET_W-1:0] MAX_OFF = OFFSET_W'(MAX_STRING_BYTES);

    typedef enum logic [2:0] {
        PH_CODE_FIRST,
        PH_CODE_REST,
        PH_DATA_SKIP,
        PH_DATA_KEEP,
        PH_DONE
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [7:0]          r_first, n_first;
    logic [2:0]          r_code_left, n_code_left;
    logic [25:0]         r_code_accum, n_code_accum;
    logic [3:0]          r_data_left, n_data_left;
    logic [63:0]         r_value, n_value;
    logic [OFFSET_W-1:0] r_offset, n_offset;
    logic [OFFSET_W-1:0] r_record_start, n_record_start;
    logic                r_decided, n_decided;

    logic                n_emit;
    splk_pkg::t_result   n_res;

    logic                code_ready;
    logic [31:0]         code;
    logic [3:0]          len;
    logic [2:0]          code_total;
    logic [1:0]          code_idx;
    logic [31:0]         code_shift;
    logic [2:0]          data_idx;

    always_comb begin
        n_phase        = r_phase;
        n_first        = r_first;
        n_code_left    = r_code_left;
        n_code_accum   = r_code_accum;
        n_data_left    = r_data_left;
        n_value        = r_value;
        n_offset       = r_offset;
        n_record_start = r_record_start;
        n_decided      = r_decided;
        n_emit         = 1'b0;
        n_res          = '0;
        code_ready     = 1'b0;
        code           = '0;
        code_total     = r_first[6] ? 3'd4 : 3'd1;
        code_idx       = 2'(code_total - r_code_left);
        code_shift     = 32'(i_data_byte) << {code_idx, 3'b000};
        len            = 4'd1 << ((r_phase == PH_CODE_FIRST) ? i_data_byte[1:0] : r_first[1:0]);
        data_idx       = 3'(len - r_data_left);

        if (i_accept) begin
            case (r_phase)
                PH_CODE_FIRST: begin
                    n_record_start = r_offset;
                    n_first        = i_data_byte;
                    if (!i_data_byte[7]) begin
                        code_ready = 1'b1;
                        code       = 32'(i_data_byte);
                    end else begin
                        n_code_left  = i_data_byte[6] ? 3'd4 : 3'd1;
                        n_code_accum = '0;
                        n_phase      = PH_CODE_REST;
                    end
                end
                PH_CODE_REST: begin
                    n_code_accum = r_code_accum | code_shift[25:0];
                    n_code_left  = r_code_left - 3'd1;
                    if (n_code_left == 3'd0) begin
                        code_ready = 1'b1;
                        code = {n_code_accum, r_first[5:0] & splk_pkg::CODE_LOW_MASK};
                    end
                end
                PH_DATA_SKIP: begin
                    n_data_left = r_data_left - 4'd1;
                    if (n_data_left == 4'd0) begin
                        n_phase = PH_CODE_FIRST;
                    end
                end
                PH_DATA_KEEP: begin
                    n_value     = r_value | (64'(i_data_byte) << {data_idx, 3'b000});
                    n_data_left = r_data_left - 4'd1;
                    if (n_data_left == 4'd0) begin
                        n_emit           = 1'b1;
                        n_res.found      = 1'b1;
                        n_res.value_low  = n_value[31:0];
                        n_res.value_high = n_value[63:32];
                        n_res.data_size  = len;
                        n_res.position   = r_record_start[splk_pkg::POS_W-1:0];
                        n_decided        = 1'b1;
                        n_phase          = PH_DONE;
                    end
                end
                default: begin
                end
            endcase

            // key complete: skip smaller or negative keys, keep equal, stop at greater
            if (code_ready) begin
                n_data_left = len;
                n_value     = '0;
                if (code[31] || (code[30:2] < i_wanted_code[30:2])) begin
                    n_phase = PH_DATA_SKIP;
                end else if (code[30:2] == i_wanted_code[30:2]) begin
                    n_phase = PH_DATA_KEEP;
                end else begin
                    n_phase        = PH_DONE;
                    n_decided      = 1'b1;
                    n_emit         = 1'b1;
                    n_res.position = n_record_start[splk_pkg::POS_W-1:0];
                end
            end

            if (r_offset < MAX_OFF) begin
                n_offset = r_offset + 1'b1;
            end

            if (i_last_byte) begin
                if (!n_emit && !n_decided) begin
                    n_emit = 1'b1;
                    case (n_phase)
                        PH_CODE_FIRST: begin
                            n_res.position = n_offset[splk_pkg::POS_W-1:0];
                        end
                        PH_DATA_KEEP: begin
                            n_res.found      = 1'b1;
                            n_res.value_low  = n_value[31:0];
                            n_res.value_high = n_value[63:32];
                            n_res.data_size  = len;
                            n_res.position   = n_record_start[splk_pkg::POS_W-1:0];
                            n_res.truncated  = 1'b1;
                        end
                        default: begin
                            n_res.position  = n_record_start[splk_pkg::POS_W-1:0];
                            n_res.truncated = 1'b1;
                        end
                    endcase
                end
                // end of string: clear for the next one
                n_phase        = PH_CODE_FIRST;
                n_first        = '0;
                n_code_left    = '0;
                n_code_accum   = '0;
                n_data_left    = '0;
                n_value        = '0;
                n_offset       = '0;
                n_record_start = '0;
                n_decided      = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_CODE_FIRST;
            r_first        <= '0;
            r_code_left    <= '0;
            r_code_accum   <= '0;
            r_data_left    <= '0;
            r_value        <= '0;
            r_offset       <= '0;
            r_record_start <= '0;
            r_decided      <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_first        <= n_first;
            r_code_left    <= n_code_left;
            r_code_accum   <= n_code_accum;
            r_data_left    <= n_data_left;
            r_value        <= n_value;
            r_offset       <= n_offset;
            r_record_start <= n_record_start;
            r_decided      <= n_decided;
        end
    end

    assign o_emit   = n_emit;
    assign o_result = n_res;

    `SPLK_ASSERT(a_decided_done, i_clk, i_rst_n, r_decided == (r_phase == PH_DONE), "decided flag and done phase disagree")
    `SPLK_ASSERT(a_last_clears, i_clk, i_rst_n, (i_accept && i_last_byte) |=> (r_phase == PH_CODE_FIRST && r_offset == '0 && !r_decided), "state not cleared after final byte")
    `SPLK_ASSERT(a_data_left_live, i_clk, i_rst_n, (r_phase == PH_DATA_SKIP || r_phase == PH_DATA_KEEP) |-> (r_data_left != '0), "data phase with no bytes left")

endmodule

@@ rtl/core/sorted_property_record_lookup.sv @@
// Sorted property record lookup: one byte per cycle while the skid is empty, one result per string.
// A deciding byte's result is registered into the output register, or into the skid if it stalls.
// Throughput: one byte per cycle while the skid is empty; the parser state update is a single registered step.
// A two-entry output stage (register plus skid) keeps bytes flowing while a result waits.
// Reset (synchronous, active low) clears the parser, the output stage and wanted_code.
`include "sorted_property_record_lookup_defines.svh"

module sorted_property_record_lookup #(
    parameter int MAX_STRING_BYTES = splk_pkg::DEF_MAX_STRING_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wanted_code_we,
    input  logic [splk_pkg::CODE_W-1:0]   i_wanted_code,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [splk_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                          i_last_byte,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_found,
    output logic [splk_pkg::WORD_W-1:0]   o_value_low,
    output logic [splk_pkg::WORD_W-1:0]   o_value_high,
    output logic [splk_pkg::SIZE_W-1:0]   o_data_size,
    output logic [splk_pkg::POS_W-1:0]    o_position,
    output logic                          o_truncated
);

    logic [splk_pkg::CODE_W-1:0] r_wanted_code;
    logic                        r_out_valid;
    logic                        r_skid_valid;
    splk_pkg::t_result           r_out;
    splk_pkg::t_result           r_skid;

    logic                        in_accept;
    logic                        emit;
    splk_pkg::t_result           result;
    logic                        out_free;
    logic                        load_from_skid;
    logic                        load_out;
    logic                        load_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wanted_code <= '0;
        end else if (i_wanted_code_we) begin
            r_wanted_code <= i_wanted_code;
        end
    end

    assign in_accept = i_valid && !r_skid_valid;

    splk_parser #(
        .MAX_STRING_BYTES(MAX_STRING_BYTES)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .i_wanted_code(r_wanted_code),
        .o_emit       (emit),
        .o_result     (result)
    );

    // output register drains this cycle or is empty
    assign out_free       = !r_out_valid || !i_stall;
    assign load_from_skid = out_free && r_skid_valid;
    assign load_out       = out_free && !r_skid_valid && emit;
    assign load_skid      = !out_free && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= r_skid_valid || emit;
            end
            if (load_from_skid) begin
                r_skid_valid <= 1'b0;
            end else if (load_skid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_from_skid) begin
            r_out <= r_skid;
        end else if (load_out) begin
            r_out <= result;
        end
        if (load_skid) begin
            r_skid <= result;
        end
    end

    assign o_stall      = r_skid_valid;
    assign o_valid      = r_out_valid;
    assign o_found      = r_out.found;
    assign o_value_low  = r_out.value_low;
    assign o_value_high = r_out.value_high;
    assign o_data_size  = r_out.data_size;
    assign o_position   = r_out.position;
    assign o_truncated  = r_out.truncated;

    `SPLK_ASSERT(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid |-> r_out_valid, "skid holds a transaction while output register is empty")
    `SPLK_ASSERT(a_found_has_size, i_clk, i_rst_n, (o_valid && o_found) |-> (o_data_size != '0), "match reported with zero data size")
    `SPLK_ASSERT(a_miss_is_zero, i_clk, i_rst_n, (o_valid && !o_found) |-> (o_value_low == '0 && o_value_high == '0 && o_data_size == '0), "miss carries data")
    `SPLK_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> (!o_valid && !o_stall), "output stage not empty after reset")

endmodule
